/* rtl/ugcl_pkg.sv */
// Shared types and constants for the uniform grid cell list binner.
// No dependencies; used by every module of the block.
`default_nettype none
package ugcl_pkg;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    // store sizes and position width
    localparam int MAX_PARTICLES = 1024;
    localparam int MAX_CELLS     = 1024;
    localparam int POS_BITS      = 16;
    localparam int CELL_W        = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

    typedef struct packed {
        logic [5:0]  grid_width;
        logic [5:0]  grid_height;
        logic [12:0] cell_size;
    } cfg_t;

    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_CELL_SIZE   = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_ADD        = 3'd0,
        OP_SET_POS    = 3'd1,
        OP_SWEEP      = 3'd2,
        OP_READ_HEAD  = 3'd3,
        OP_READ_LINKS = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [9:0]  particle_id;
        logic [9:0]  cell_id;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  assigned_id;
        logic [9:0]  cell_of_particle;
        logic [10:0] link_value;
        logic [10:0] prev_value;
        logic [10:0] moved_count;
    } result_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_DIV,
        CS_FIN
    } calc_state_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_CALC,
        ST_PUSH_RD,
        ST_PUSH_WR,
        ST_PUSH_FIX,
        ST_SET_RD,
        ST_SET_WR,
        ST_SET_CALC,
        ST_HEAD_RD,
        ST_HEAD_Q,
        ST_LNK_RD,
        ST_LNK_Q,
        ST_LNK_CALC,
        ST_SW_HEAD,
        ST_SW_HQ,
        ST_SW_NEXT,
        ST_SW_RQ,
        ST_SW_CALC,
        ST_SW_U1,
        ST_SW_U1Q,
        ST_SW_U2,
        ST_SW_U2Q,
        ST_DONE
    } core_state_t;

endpackage
`default_nettype wire

/* rtl/ugcl_cell_calc.sv */
// Position to grid cell unit: bit-serial divide of x and y by cell size,
// then clamp and row * width + col. Depends on ugcl_pkg.
`default_nettype none
module ugcl_cell_calc (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ugcl_pkg::cfg_t                cfg,
    input  wire logic                          start,
    input  wire logic [ugcl_pkg::POS_BITS-1:0] x,
    input  wire logic [ugcl_pkg::POS_BITS-1:0] y,
    output logic                               done,
    output logic [ugcl_pkg::CELL_W-1:0]        cell_idx
);
    import ugcl_pkg::*;

    localparam int CW   = CELL_W;
    localparam int CNTW = $clog2(POS_BITS);

    calc_state_t          state_reg, state_next;
    logic [CNTW-1:0]      cnt_reg, cnt_next;
    logic [POS_BITS-1:0]  xs_reg, xs_next, ys_reg, ys_next;
    logic [13:0]          rx_reg, rx_next, ry_reg, ry_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cell_reg, cell_next;

    logic [12:0] cs_eff;
    logic [5:0]  gw_eff, gh_eff, gw_m1, gh_m1;
    logic [13:0] rsx, rsy, cs_ext;
    logic [4:0]  col, row;
    logic [9:0]  full_cell;

    always_comb begin
        cs_eff = (cfg.cell_size == 13'd0) ? 13'd1 :
                 (cfg.cell_size > 13'd4096) ? 13'd4096 : cfg.cell_size;
        gw_eff = (cfg.grid_width == 6'd0) ? 6'd1 :
                 (cfg.grid_width > 6'd32) ? 6'd32 : cfg.grid_width;
        gh_eff = (cfg.grid_height == 6'd0) ? 6'd1 :
                 (cfg.grid_height > 6'd32) ? 6'd32 : cfg.grid_height;
        gw_m1  = gw_eff - 6'd1;
        gh_m1  = gh_eff - 6'd1;
        cs_ext = {1'b0, cs_eff};
        rsx    = {rx_reg[12:0], xs_reg[POS_BITS-1]};
        rsy    = {ry_reg[12:0], ys_reg[POS_BITS-1]};
        // quotients sit in xs_reg / ys_reg once the divide is over
        col = (32'(xs_reg) > 32'(gw_m1)) ? gw_m1[4:0] : xs_reg[4:0];
        row = (32'(ys_reg) > 32'(gh_m1)) ? gh_m1[4:0] : ys_reg[4:0];
        full_cell = 10'(row * gw_eff) + 10'(col);
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        xs_next    = xs_reg;
        ys_next    = ys_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        done_next  = 1'b0;
        cell_next  = cell_reg;
        unique case (state_reg)
            CS_IDLE: begin
                if (start) begin
                    xs_next    = x;
                    ys_next    = y;
                    rx_next    = '0;
                    ry_next    = '0;
                    cnt_next   = CNTW'(POS_BITS - 1);
                    state_next = CS_DIV;
                end
            end
            CS_DIV: begin
                if (rsx >= cs_ext) begin
                    rx_next = rsx - cs_ext;
                    xs_next = {xs_reg[POS_BITS-2:0], 1'b1};
                end else begin
                    rx_next = rsx;
                    xs_next = {xs_reg[POS_BITS-2:0], 1'b0};
                end
                if (rsy >= cs_ext) begin
                    ry_next = rsy - cs_ext;
                    ys_next = {ys_reg[POS_BITS-2:0], 1'b1};
                end else begin
                    ry_next = rsy;
                    ys_next = {ys_reg[POS_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNTW'(1);
                if (cnt_reg == '0) begin
                    state_next = CS_FIN;
                end
            end
            CS_FIN: begin
                if (32'(full_cell) >= 32'(MAX_CELLS)) begin
                    cell_next = CW'(MAX_CELLS - 1);
                end else begin
                    cell_next = CW'(full_cell);
                end
                done_next  = 1'b1;
                state_next = CS_IDLE;
            end
            default: state_next = CS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg  <= cnt_next;
        xs_reg   <= xs_next;
        ys_reg   <= ys_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        cell_reg <= cell_next;
    end

    assign done     = done_reg;
    assign cell_idx = cell_reg;

endmodule
`default_nettype wire

/* rtl/ugcl_core.sv */
// Sequencer with the cell head memory and the particle record memory.
// Depends on ugcl_pkg and ugcl_cell_calc.
`default_nettype none
module ugcl_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ugcl_pkg::cfg_t    cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ugcl_pkg::cmd_t    cmd,
    output logic                   out_valid,
    input  wire logic              out_take,
    output ugcl_pkg::result_t      result
);
    import ugcl_pkg::*;

    localparam int PW = $clog2(MAX_PARTICLES);
    localparam int LW = $clog2(MAX_PARTICLES + 1);
    localparam int CW = CELL_W;
    localparam int RW = 2 * LW + 2 * POS_BITS;
    localparam logic [LW-1:0] NONE = LW'(MAX_PARTICLES);
    localparam logic [CW-1:0] LAST_CELL = CW'(MAX_CELLS - 1);

    // memories: record = {next, prev, x, y}
    logic [LW-1:0] hmem [MAX_CELLS];
    logic [RW-1:0] pmem [MAX_PARTICLES];

    logic          hm_we, hm_re;
    logic [CW-1:0] hm_waddr, hm_raddr;
    logic [LW-1:0] hm_wdata, hm_q;
    logic          pm_we, pm_re;
    logic [PW-1:0] pm_waddr, pm_raddr;
    logic [RW-1:0] pm_wdata, pm_q;

    always_ff @(posedge aclk) begin
        if (hm_we) begin
            hmem[hm_waddr] <= hm_wdata;
        end
        if (hm_re) begin
            hm_q <= hmem[hm_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pm_we) begin
            pmem[pm_waddr] <= pm_wdata;
        end
        if (pm_re) begin
            pm_q <= pmem[pm_raddr];
        end
    end

    logic [LW-1:0]       q_next, q_prev;
    logic [POS_BITS-1:0] q_x, q_y;
    assign q_next = pm_q[RW-1 -: LW];
    assign q_prev = pm_q[2*POS_BITS +: LW];
    assign q_x    = pm_q[POS_BITS +: POS_BITS];
    assign q_y    = pm_q[POS_BITS-1:0];

    core_state_t         state_reg, state_next;
    logic [2:0]          op_reg, op_next;
    logic [9:0]          pid_reg, pid_next, cid_reg, cid_next;
    logic [POS_BITS-1:0] px_reg, px_next, py_reg, py_next;
    logic [LW-1:0]       count_reg, count_next;
    logic [LW-1:0]       cur_reg, cur_next, nxt_reg, nxt_next, pv_reg, pv_next;
    logic [LW-1:0]       h_reg, h_next, moved_reg, moved_next;
    logic [CW-1:0]       nc_reg, nc_next, c_reg, c_next, clr_reg, clr_next;
    logic [1:0]          rs_reg, rs_next;
    logic [PW-1:0]       rid_reg, rid_next;
    logic [CW-1:0]       rcell_reg, rcell_next;
    logic [LW-1:0]       rlink_reg, rlink_next, rprev_reg, rprev_next, rmov_reg, rmov_next;

    logic                calc_start, calc_done;
    logic [POS_BITS-1:0] calc_x, calc_y;
    logic [CW-1:0]       calc_cell;

    ugcl_cell_calc u_calc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .start    (calc_start),
        .x        (calc_x),
        .y        (calc_y),
        .done     (calc_done),
        .cell_idx (calc_cell)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);

    always_comb begin
        result.status           = rs_reg;
        result.assigned_id      = 10'(rid_reg);
        result.cell_of_particle = 10'(rcell_reg);
        result.link_value       = 11'(rlink_reg);
        result.prev_value       = 11'(rprev_reg);
        result.moved_count      = 11'(rmov_reg);
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        pid_next   = pid_reg;
        cid_next   = cid_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        nxt_next   = nxt_reg;
        pv_next    = pv_reg;
        h_next     = h_reg;
        moved_next = moved_reg;
        nc_next    = nc_reg;
        c_next     = c_reg;
        clr_next   = clr_reg;
        rs_next    = rs_reg;
        rid_next   = rid_reg;
        rcell_next = rcell_reg;
        rlink_next = rlink_reg;
        rprev_next = rprev_reg;
        rmov_next  = rmov_reg;

        hm_we = 1'b0; hm_waddr = nc_reg; hm_wdata = cur_reg;
        hm_re = 1'b0; hm_raddr = nc_reg;
        pm_we = 1'b0; pm_waddr = PW'(cur_reg); pm_wdata = pm_q;
        pm_re = 1'b0; pm_raddr = PW'(cur_reg);
        calc_start = 1'b0;
        calc_x = px_reg;
        calc_y = py_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                hm_we    = 1'b1;
                hm_waddr = clr_reg;
                hm_wdata = NONE;
                clr_next = clr_reg + CW'(1);
                if (clr_reg == LAST_CELL) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    op_next    = cmd.opcode;
                    pid_next   = cmd.particle_id;
                    cid_next   = cmd.cell_id;
                    px_next    = POS_BITS'(cmd.pos_x);
                    py_next    = POS_BITS'(cmd.pos_y);
                    rs_next    = STAT_OK;
                    rid_next   = '0;
                    rcell_next = '0;
                    rlink_next = '0;
                    rprev_next = '0;
                    rmov_next  = '0;
                    unique case (cmd.opcode)
                        OP_ADD: begin
                            if (count_reg == NONE) begin
                                rs_next    = STAT_FULL;
                                state_next = ST_DONE;
                            end else begin
                                cur_next   = count_reg;
                                state_next = ST_ADD_CALC;
                            end
                        end
                        OP_SET_POS: begin
                            if (32'(cmd.particle_id) < 32'(count_reg)) begin
                                state_next = ST_SET_RD;
                            end else begin
                                rs_next    = STAT_RANGE;
                                state_next = ST_DONE;
                            end
                        end
                        OP_SWEEP: begin
                            c_next     = '0;
                            moved_next = '0;
                            state_next = ST_SW_HEAD;
                        end
                        OP_READ_HEAD: begin
                            if (32'(cmd.cell_id) < 32'(MAX_CELLS)) begin
                                state_next = ST_HEAD_RD;
                            end else begin
                                rs_next    = STAT_RANGE;
                                state_next = ST_DONE;
                            end
                        end
                        OP_READ_LINKS: begin
                            if (32'(cmd.particle_id) < 32'(count_reg)) begin
                                state_next = ST_LNK_RD;
                            end else begin
                                rs_next    = STAT_RANGE;
                                state_next = ST_DONE;
                            end
                        end
                        default: begin
                            rs_next    = STAT_RANGE;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_ADD_CALC: begin
                // divider was started on entry; wait here for the cell
                if (calc_done) begin
                    nc_next    = calc_cell;
                    state_next = ST_PUSH_RD;
                end
            end
            ST_PUSH_RD: begin
                hm_re      = 1'b1;
                hm_raddr   = nc_reg;
                state_next = ST_PUSH_WR;
            end
            ST_PUSH_WR: begin
                h_next   = hm_q;
                hm_we    = 1'b1;
                hm_waddr = nc_reg;
                hm_wdata = cur_reg;
                pm_we    = 1'b1;
                pm_waddr = PW'(cur_reg);
                pm_wdata = {hm_q, NONE, px_reg, py_reg};
                // add result; a sweep overwrites these at its end
                rs_next    = STAT_OK;
                rid_next   = PW'(cur_reg);
                rcell_next = nc_reg;
                rlink_next = hm_q;
                rprev_next = NONE;
                if (hm_q != NONE) begin
                    pm_re      = 1'b1;
                    pm_raddr   = PW'(hm_q);
                    state_next = ST_PUSH_FIX;
                end else if (op_reg == OP_ADD) begin
                    count_next = count_reg + LW'(1);
                    state_next = ST_DONE;
                end else begin
                    moved_next = moved_reg + LW'(1);
                    cur_next   = nxt_reg;
                    state_next = ST_SW_NEXT;
                end
            end
            ST_PUSH_FIX: begin
                pm_we    = 1'b1;
                pm_waddr = PW'(h_reg);
                pm_wdata = {q_next, cur_reg, q_x, q_y};
                if (op_reg == OP_ADD) begin
                    count_next = count_reg + LW'(1);
                    state_next = ST_DONE;
                end else begin
                    moved_next = moved_reg + LW'(1);
                    cur_next   = nxt_reg;
                    state_next = ST_SW_NEXT;
                end
            end
            ST_SET_RD: begin
                pm_re      = 1'b1;
                pm_raddr   = PW'(pid_reg);
                calc_start = 1'b1;
                state_next = ST_SET_WR;
            end
            ST_SET_WR: begin
                pm_we      = 1'b1;
                pm_waddr   = PW'(pid_reg);
                pm_wdata   = {q_next, q_prev, px_reg, py_reg};
                state_next = ST_SET_CALC;
            end
            ST_SET_CALC: begin
                if (calc_done) begin
                    rcell_next = calc_cell;
                    state_next = ST_DONE;
                end
            end
            ST_HEAD_RD: begin
                hm_re      = 1'b1;
                hm_raddr   = CW'(cid_reg);
                state_next = ST_HEAD_Q;
            end
            ST_HEAD_Q: begin
                rlink_next = hm_q;
                state_next = ST_DONE;
            end
            ST_LNK_RD: begin
                pm_re      = 1'b1;
                pm_raddr   = PW'(pid_reg);
                state_next = ST_LNK_Q;
            end
            ST_LNK_Q: begin
                rlink_next = q_next;
                rprev_next = q_prev;
                calc_start = 1'b1;
                calc_x     = q_x;
                calc_y     = q_y;
                state_next = ST_LNK_CALC;
            end
            ST_LNK_CALC: begin
                if (calc_done) begin
                    rcell_next = calc_cell;
                    state_next = ST_DONE;
                end
            end
            ST_SW_HEAD: begin
                hm_re      = 1'b1;
                hm_raddr   = c_reg;
                state_next = ST_SW_HQ;
            end
            ST_SW_HQ: begin
                cur_next   = hm_q;
                state_next = ST_SW_NEXT;
            end
            ST_SW_NEXT: begin
                if (cur_reg != NONE) begin
                    pm_re      = 1'b1;
                    pm_raddr   = PW'(cur_reg);
                    state_next = ST_SW_RQ;
                end else if (c_reg == LAST_CELL) begin
                    rs_next    = STAT_OK;
                    rid_next   = '0;
                    rcell_next = '0;
                    rlink_next = '0;
                    rprev_next = '0;
                    rmov_next  = moved_reg;
                    state_next = ST_DONE;
                end else begin
                    c_next     = c_reg + CW'(1);
                    state_next = ST_SW_HEAD;
                end
            end
            ST_SW_RQ: begin
                nxt_next   = q_next;
                pv_next    = q_prev;
                px_next    = q_x;
                py_next    = q_y;
                calc_start = 1'b1;
                calc_x     = q_x;
                calc_y     = q_y;
                state_next = ST_SW_CALC;
            end
            ST_SW_CALC: begin
                if (calc_done) begin
                    nc_next = calc_cell;
                    if (calc_cell == c_reg) begin
                        cur_next   = nxt_reg;
                        state_next = ST_SW_NEXT;
                    end else begin
                        state_next = ST_SW_U1;
                    end
                end
            end
            ST_SW_U1: begin
                // unlink: predecessor's next, or the cell head
                if (pv_reg != NONE) begin
                    pm_re      = 1'b1;
                    pm_raddr   = PW'(pv_reg);
                    state_next = ST_SW_U1Q;
                end else begin
                    hm_we      = 1'b1;
                    hm_waddr   = c_reg;
                    hm_wdata   = nxt_reg;
                    state_next = ST_SW_U2;
                end
            end
            ST_SW_U1Q: begin
                pm_we      = 1'b1;
                pm_waddr   = PW'(pv_reg);
                pm_wdata   = {nxt_reg, q_prev, q_x, q_y};
                state_next = ST_SW_U2;
            end
            ST_SW_U2: begin
                if (nxt_reg != NONE) begin
                    pm_re      = 1'b1;
                    pm_raddr   = PW'(nxt_reg);
                    state_next = ST_SW_U2Q;
                end else begin
                    state_next = ST_PUSH_RD;
                end
            end
            ST_SW_U2Q: begin
                pm_we      = 1'b1;
                pm_waddr   = PW'(nxt_reg);
                pm_wdata   = {q_next, pv_reg, q_x, q_y};
                state_next = ST_PUSH_RD;
            end
            ST_DONE: begin
                if (out_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // divider kicks off as an add enters its calc wait
        if (state_reg == ST_IDLE && state_next == ST_ADD_CALC) begin
            calc_start = 1'b1;
            calc_x     = POS_BITS'(cmd.pos_x);
            calc_y     = POS_BITS'(cmd.pos_y);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            count_reg <= '0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            clr_reg   <= clr_next;
        end
        op_reg    <= op_next;
        pid_reg   <= pid_next;
        cid_reg   <= cid_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        cur_reg   <= cur_next;
        nxt_reg   <= nxt_next;
        pv_reg    <= pv_next;
        h_reg     <= h_next;
        moved_reg <= moved_next;
        nc_reg    <= nc_next;
        c_reg     <= c_next;
        rs_reg    <= rs_next;
        rid_reg   <= rid_next;
        rcell_reg <= rcell_next;
        rlink_reg <= rlink_next;
        rprev_reg <= rprev_next;
        rmov_reg  <= rmov_next;
    end

endmodule
`default_nettype wire

/* rtl/uniform_grid_cell_list_binner_top.sv */
// Uniform grid binner top: config registers, stream ports, output register.
// Depends on ugcl_pkg and ugcl_core.
//
// Usage:
//  - Commands arrive on the s_ stream (opcode in s_tuser), one result per
//    command leaves on the m_ stream. Config registers are written through
//    the cfg_wr_* port while the block is idle; the user keeps to this, the
//    block does not enforce it.
//  - One command is processed at a time. Set position, read links and add
//    wait on the bit-serial divider that maps a position to a cell, and all
//    steps go through the single read and write port of each memory.
//  - A sweep visits all MAX_CELLS heads and each particle, and relinks a
//    particle whose cell has changed.
//  - After reset the head memory is cleared one entry per cycle, so
//    s_tready stays low until the clear is done; config writes are taken.
//  - The result sits in an output register: while the receiver stalls, the
//    next command is still taken and processed, and waits at its end until
//    the register frees up.
`default_nettype none
module uniform_grid_cell_list_binner_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [1:0]                        cfg_wr_addr,
    input  wire logic [12:0]                       cfg_wr_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // particle_id[9:0], cell_id[19:10], pos_x[35:20], pos_y[51:36], zero pad
    input  wire logic [ugcl_pkg::IN_TDATA_W-1:0]   s_tdata,
    // opcode[2:0]
    input  wire logic [2:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // status[1:0], assigned_id[11:2], cell_of_particle[21:12],
    // link_value[32:22], prev_value[43:33], moved_count[54:44], zero pad
    output logic [ugcl_pkg::OUT_TDATA_W-1:0]       m_tdata
);
    import ugcl_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    cmd;
    result_t core_res, out_reg;
    logic    core_valid, out_take, m_valid_reg;

    // config registers, reset to a 32 x 32 grid of 16-unit cells
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grid_width  <= 6'd32;
            cfg_reg.grid_height <= 6'd32;
            cfg_reg.cell_size   <= 13'd16;
        end else if (cfg_wr_en) begin
            if (cfg_wr_addr == REG_GRID_WIDTH) begin
                cfg_reg.grid_width <= cfg_wr_data[5:0];
            end
            if (cfg_wr_addr == REG_GRID_HEIGHT) begin
                cfg_reg.grid_height <= cfg_wr_data[5:0];
            end
            if (cfg_wr_addr == REG_CELL_SIZE) begin
                cfg_reg.cell_size <= cfg_wr_data;
            end
        end
    end

    always_comb begin
        cmd.opcode      = s_tuser;
        cmd.particle_id = s_tdata[9:0];
        cmd.cell_id     = s_tdata[19:10];
        cmd.pos_x       = s_tdata[35:20];
        cmd.pos_y       = s_tdata[51:36];
    end

    ugcl_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .cmd       (cmd),
        .out_valid (core_valid),
        .out_take  (out_take),
        .result    (core_res)
    );

    // output register: free when empty or drained this cycle
    assign out_take = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_take) begin
            m_valid_reg <= core_valid;
        end
        if (out_take && core_valid) begin
            out_reg <= core_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_reg.moved_count, out_reg.prev_value, out_reg.link_value,
                       out_reg.cell_of_particle, out_reg.assigned_id, out_reg.status};

endmodule
`default_nettype wire

/* rtl/ugcl_checker.sv */
// Port-level checks for the binner top, attached by bind.
// Depends on ugcl_pkg widths only.
`default_nettype none
module ugcl_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [ugcl_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    // reset leaves no result pending and blocks input for the clear pass
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("ready or valid high right after reset");

    // one command at a time: an accepted transaction drops ready
    a_one_at_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted back to back");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // status code is always a defined one
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("undefined status code");

endmodule

bind uniform_grid_cell_list_binner_top ugcl_checker u_ugcl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

/* tb/uniform_grid_cell_list_binner_top_tb.sv */
// Self-checking testbench for uniform_grid_cell_list_binner_top.
// Depends on ugcl_pkg and the binner RTL. A built-in cell-list predictor checks every result.
`timescale 1ns / 1ps
module uniform_grid_cell_list_binner_top_tb;
    import ugcl_pkg::*;

    localparam int NPART = 1024;
    localparam int NCELL = 1024;
    localparam logic [10:0] NO_LINK = 11'd1024;
    // opcode values with no defined operation
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_MID   = 3'd6;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam int STALL_LIMIT = 200000;

    typedef struct {
        logic [2:0]  op;
        logic [9:0]  pid;
        logic [9:0]  cid;
        logic [15:0] x;
        logic [15:0] y;
    } cmd_item_t;

    typedef struct {
        logic [1:0]  status;
        logic [9:0]  aid;
        logic [9:0]  cop;
        logic [10:0] link;
        logic [10:0] prev;
        logic [10:0] moved;
    } bin_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_addr = '0;
    logic [12:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic [2:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    uniform_grid_cell_list_binner_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_addr(cfg_wr_addr), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------- binner shadow state ----------------
    logic [5:0]  gw_reg = 6'd32;
    logic [5:0]  gh_reg = 6'd32;
    logic [12:0] cs_reg = 13'd16;
    logic [10:0] head_mem [NCELL];
    logic [10:0] next_mem [NPART];
    logic [10:0] prev_mem [NPART];
    logic [15:0] xs_mem [NPART];
    logic [15:0] ys_mem [NPART];
    int stored_cnt = 0;

    cmd_item_t   cmd_q[$];
    bin_result_t expected_q[$];

    int errors = 0;
    int n_results = 0;
    int n_adds = 0;
    int n_sweeps = 0;
    int n_moved = 0;
    int n_rejects = 0;
    bit quiet = 0;       // no idling on either side in the final stretch
    bit cmd_taken = 0;

    initial begin
        for (int i = 0; i < NCELL; i++) head_mem[i] = NO_LINK;
    end

    // cell of a position, with the register clamps applied
    function automatic int grid_cell(logic [15:0] x, logic [15:0] y);
        int gw, gh, cs, col, row, c;
        gw = (gw_reg == 0) ? 1 : (gw_reg > 32) ? 32 : gw_reg;
        gh = (gh_reg == 0) ? 1 : (gh_reg > 32) ? 32 : gh_reg;
        cs = (cs_reg == 0) ? 1 : (cs_reg > 4096) ? 4096 : cs_reg;
        col = x / cs;
        row = y / cs;
        if (col > gw - 1) col = gw - 1;
        if (row > gh - 1) row = gh - 1;
        c = row * gw + col;
        if (c >= NCELL) c = NCELL - 1;
        return c;
    endfunction

    function automatic void link_at_head(int idx, int c);
        logic [10:0] h;
        h = head_mem[c];
        if (h < NPART) prev_mem[h] = 11'(idx);
        next_mem[idx] = h;
        prev_mem[idx] = NO_LINK;
        head_mem[c] = 11'(idx);
    endfunction

    function automatic int rebin_all();
        int moved, cur, nxt, pv, nc, guard;
        moved = 0;
        for (int c = 0; c < NCELL; c++) begin
            cur = head_mem[c];
            guard = 0;
            while (cur < NPART && guard <= NPART) begin
                nxt = next_mem[cur];
                pv = prev_mem[cur];
                nc = grid_cell(xs_mem[cur], ys_mem[cur]);
                guard++;
                if (nc != c) begin
                    if (pv < NPART) next_mem[pv] = 11'(nxt);
                    else head_mem[c] = 11'(nxt);
                    if (nxt < NPART) prev_mem[nxt] = 11'(pv);
                    link_at_head(cur, nc);
                    moved++;
                end
                cur = nxt;
            end
        end
        return moved;
    endfunction

    function automatic bin_result_t apply_cmd(cmd_item_t t);
        bin_result_t r;
        int c;
        r = '{STAT_RANGE, 10'd0, 10'd0, 11'd0, 11'd0, 11'd0};
        case (t.op)
            OP_ADD: begin
                if (stored_cnt >= NPART) begin
                    r.status = STAT_FULL;
                end else begin
                    c = grid_cell(t.x, t.y);
                    xs_mem[stored_cnt] = t.x;
                    ys_mem[stored_cnt] = t.y;
                    link_at_head(stored_cnt, c);
                    r = '{STAT_OK, stored_cnt[9:0], c[9:0], next_mem[stored_cnt], NO_LINK,
                          11'd0};
                    stored_cnt++;
                    n_adds++;
                end
            end
            OP_SET_POS: begin
                if (t.pid < stored_cnt) begin
                    xs_mem[t.pid] = t.x;
                    ys_mem[t.pid] = t.y;
                    c = grid_cell(t.x, t.y);
                    r.status = STAT_OK;
                    r.cop = c[9:0];
                end
            end
            OP_SWEEP: begin
                c = rebin_all();
                r.status = STAT_OK;
                r.moved = c[10:0];
                n_sweeps++;
                n_moved += c;
            end
            OP_READ_HEAD: begin
                r.status = STAT_OK;   // every 10-bit cell index is inside the store
                r.link = head_mem[t.cid];
            end
            OP_READ_LINKS: begin
                if (t.pid < stored_cnt) begin
                    c = grid_cell(xs_mem[t.pid], ys_mem[t.pid]);
                    r = '{STAT_OK, 10'd0, c[9:0], next_mem[t.pid], prev_mem[t.pid], 11'd0};
                end
            end
            default: ;
        endcase
        if (r.status != STAT_OK) n_rejects++;
        return r;
    endfunction

    // ---------------- driver ----------------
    int src_gap = 0;
    always @(posedge aclk) begin
        cmd_item_t t;
        bin_result_t r;
        cmd_taken <= s_tvalid && s_tready;
        if (s_tvalid && s_tready) begin
            t.op = s_tuser;
            t.pid = s_tdata[9:0];
            t.cid = s_tdata[19:10];
            t.x = s_tdata[35:20];
            t.y = s_tdata[51:36];
            r = apply_cmd(t);
            expected_q = {expected_q, r};
        end
    end

    always @(negedge aclk) begin
        cmd_item_t t;
        if (aresetn && (!s_tvalid || cmd_taken)) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                src_gap = $urandom_range(0, 12);
                s_tvalid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                t = cmd_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= t.op;
                s_tdata <= {4'd0, t.y, t.x, t.cid, t.pid};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- receiver and checker ----------------
    int snk_gap = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            snk_gap = $urandom_range(0, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        bin_result_t got, want;
        if (m_tvalid && m_tready) begin
            got = '{m_tdata[1:0], m_tdata[11:2], m_tdata[21:12], m_tdata[32:22],
                    m_tdata[43:33], m_tdata[54:44]};
            n_results++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transaction %h", $time, m_tdata);
            end else begin
                want = expected_q.pop_front();
                if (got.status !== want.status) begin
                    errors++;
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                end
                if (got.aid !== want.aid) begin
                    errors++;
                    $display("%0t: assigned_id exp %0d got %0d", $time, want.aid, got.aid);
                end
                if (got.cop !== want.cop) begin
                    errors++;
                    $display("%0t: cell exp %0d got %0d", $time, want.cop, got.cop);
                end
                if (got.link !== want.link) begin
                    errors++;
                    $display("%0t: link exp %0d got %0d", $time, want.link, got.link);
                end
                if (got.prev !== want.prev) begin
                    errors++;
                    $display("%0t: prev exp %0d got %0d", $time, want.prev, got.prev);
                end
                if (got.moved !== want.moved) begin
                    errors++;
                    $display("%0t: moved exp %0d got %0d", $time, want.moved, got.moved);
                end
            end
        end
    end

    // Watchdog: cycles with pending work but no transaction on either side.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cmd_q.size() == 0 && !s_tvalid && expected_q.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL uniform_grid_cell_list_binner_top");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------
    int issued_adds = 0;   // generator-side view of the particle count

    task automatic queue_cmd(logic [2:0] op, logic [9:0] pid, logic [9:0] cid,
                             logic [15:0] x, logic [15:0] y);
        cmd_item_t t;
        t = '{op, pid, cid, x, y};
        cmd_q = {cmd_q, t};
        if (op == OP_ADD && issued_adds < NPART) issued_adds++;
    endtask

    task automatic write_reg(reg_idx_t idx, logic [12:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_addr <= idx;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_GRID_WIDTH:  gw_reg = v[5:0];
            REG_GRID_HEIGHT: gh_reg = v[5:0];
            default:         cs_reg = v;
        endcase
    endtask

    task automatic drain();
        wait (cmd_q.size() == 0 && !s_tvalid && expected_q.size() == 0);
        @(negedge aclk);
    endtask

    // positions half the time inside the grid's span so that cells spread out
    function automatic logic [15:0] rand_coord(int span);
        if ($urandom_range(0, 1)) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, (span > 65535) ? 65535 : span));
    endfunction

    task automatic queue_random(int n);
        int span, k;
        logic [9:0] pid;
        span = (gw_reg > gh_reg ? gw_reg : gh_reg) * (cs_reg == 0 ? 1 : cs_reg) + 16;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (issued_adds > 0 && $urandom_range(0, 9) != 0)
                pid = 10'($urandom_range(0, issued_adds - 1));
            else
                pid = 10'($urandom_range(0, 1023));
            if (k < 30)
                queue_cmd(OP_ADD, 10'($urandom), 10'($urandom), rand_coord(span),
                          rand_coord(span));
            else if (k < 55)
                queue_cmd(OP_SET_POS, pid, 10'($urandom), rand_coord(span), rand_coord(span));
            else if (k < 57)
                queue_cmd(OP_SWEEP, 10'($urandom), 10'($urandom), 16'($urandom),
                          16'($urandom));
            else if (k < 73)
                queue_cmd(OP_READ_HEAD, 10'($urandom), 10'($urandom), 16'($urandom),
                          16'($urandom));
            else if (k < 95)
                queue_cmd(OP_READ_LINKS, pid, 10'($urandom), 16'($urandom), 16'($urandom));
            else
                queue_cmd(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), pid,
                          10'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    // grid width, grid height, cell size per phase; out-of-range values exercise the clamps
    int phase_cfg [6][3] = '{'{32, 32, 16}, '{1, 1, 1}, '{32, 32, 4096},
                             '{5, 7, 3}, '{0, 63, 0}, '{63, 0, 8191}};

    initial begin
        // reset, and queue the directed set while the head memory clears
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        queue_cmd(OP_READ_LINKS, 10'd0, 10'd0, 16'd0, 16'd0);      // empty store
        queue_cmd(OP_SET_POS, 10'd1023, 10'd0, 16'd5, 16'd5);      // bad particle
        queue_cmd(OP_READ_HEAD, 10'd0, 10'd0, 16'd0, 16'd0);
        queue_cmd(OP_READ_HEAD, 10'd0, 10'd1023, 16'd0, 16'd0);
        queue_cmd(OP_ADD, 10'd0, 10'd0, 16'd0, 16'd0);
        queue_cmd(OP_ADD, 10'd1023, 10'd1023, 16'hFFFF, 16'hFFFF); // clamps to last cell
        queue_cmd(OP_ADD, 10'd0, 10'd0, 16'd3, 16'd7);             // same cell as first
        queue_cmd(OP_ADD, 10'd0, 10'd0, 16'd17, 16'hFFFF);
        queue_cmd(OP_READ_LINKS, 10'd0, 10'd0, 16'd0, 16'd0);
        queue_cmd(OP_READ_LINKS, 10'd2, 10'd0, 16'd0, 16'd0);
        queue_cmd(OP_READ_LINKS, 10'd4, 10'd0, 16'd0, 16'd0);      // just past the count
        queue_cmd(OP_READ_HEAD, 10'd0, 10'd0, 16'd0, 16'd0);
        queue_cmd(OP_SET_POS, 10'd0, 10'd0, 16'hFFFF, 16'd0);
        queue_cmd(OP_SET_POS, 10'd3, 10'd0, 16'd0, 16'd0);
        queue_cmd(OP_SWEEP, 10'd0, 10'd0, 16'd0, 16'd0);
        queue_cmd(OP_READ_HEAD, 10'd0, 10'd31, 16'd0, 16'd0);
        queue_cmd(OP_READ_LINKS, 10'd0, 10'd0, 16'd0, 16'd0);
        queue_cmd(OP_SWEEP, 10'd0, 10'd0, 16'd0, 16'd0);           // nothing to move
        queue_cmd(OP_SPARE_FIRST, 10'd0, 10'd0, 16'd0, 16'd0);
        queue_cmd(OP_SPARE_MID, 10'd0, 10'd0, 16'd0, 16'd0);
        queue_cmd(OP_SPARE_LAST, 10'd1023, 10'd1023, 16'hFFFF, 16'hFFFF);
        drain();

        // random phases, each under its own grid setting
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_GRID_WIDTH, 13'(phase_cfg[p][0]));
            write_reg(REG_GRID_HEIGHT, 13'(phase_cfg[p][1]));
            write_reg(REG_CELL_SIZE, 13'(phase_cfg[p][2]));
            queue_random(166);
            queue_cmd(OP_SWEEP, 10'd0, 10'd0, 16'd0, 16'd0);      // rebin under this phase's setting
            drain();
        end

        // final stretch without idling: fill the store, then hit it when full
        quiet = 1;
        write_reg(REG_GRID_WIDTH, 13'd32);
        write_reg(REG_GRID_HEIGHT, 13'd32);
        write_reg(REG_CELL_SIZE, 13'd1);
        while (issued_adds < NPART)
            queue_cmd(OP_ADD, 10'd0, 10'd0, 16'($urandom_range(0, 40)),
                      16'($urandom_range(0, 40)));
        queue_cmd(OP_ADD, 10'd0, 10'd0, 16'd1, 16'd1);
        queue_cmd(OP_ADD, 10'd0, 10'd0, 16'hFFFF, 16'hFFFF);
        queue_cmd(OP_SET_POS, 10'd1023, 10'd0, 16'd0, 16'd0);
        queue_cmd(OP_SWEEP, 10'd0, 10'd0, 16'd0, 16'd0);
        queue_cmd(OP_READ_LINKS, 10'd1023, 10'd0, 16'd0, 16'd0);
        queue_cmd(OP_READ_HEAD, 10'd0, 10'd1023, 16'd0, 16'd0);
        drain();
        repeat (50) @(negedge aclk);

        $display("Covered %0d results: %0d adds, %0d sweeps moving %0d particles,",
                 n_results, n_adds, n_sweeps, n_moved);
        $display("%0d rejected commands, 7 register settings incl. clamped extremes.",
                 n_rejects);
        if (errors == 0) begin
            $display("PASS uniform_grid_cell_list_binner_top");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAIL uniform_grid_cell_list_binner_top");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/ugcl_pkg.sv
rtl/ugcl_cell_calc.sv
rtl/ugcl_core.sv
rtl/uniform_grid_cell_list_binner_top.sv
rtl/ugcl_checker.sv
tb/uniform_grid_cell_list_binner_top_tb.sv
